/* rtl/core/prob_label_color_blend_argmax_top_defines.svh */
// assertion macros used by the checker file
`ifndef PROB_LABEL_COLOR_BLEND_ARGMAX_TOP_DEFINES_SVH
`define PROB_LABEL_COLOR_BLEND_ARGMAX_TOP_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define PLCBA_ASSERT_CLK(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("assertion failed");

// concurrent assertion on the default clk / arst_n names
`define PLCBA_ASSERT(lbl, prop) \
	`PLCBA_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

/* rtl/core/plcba_pkg.sv */
// shared constants and types of the probability label compositor
package plcba_pkg;

	localparam int VOXEL_COUNT = 65536;
	localparam int VOX_AW      = $clog2(VOXEL_COUNT);
	localparam int VOX_W       = 16;
	localparam int CH_W        = 8;
	localparam int NUM_CH      = 4;
	localparam int PROD_W      = 2 * CH_W;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;
	localparam logic [CH_W-1:0] ALPHA  = 8'd255;

	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0] color;      // [0]=r [1]=g [2]=b [3]=a
		logic [CH_W-1:0]             best_label;
		logic [CH_W-1:0]             best_prob;
	} entry_t;

	typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_t;

endpackage

/* rtl/core/plcba_if.sv */
// valid/ready channel interfaces for samples and results
interface plcba_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] voxel_index;
	logic [7:0]  label_index;
	logic        first_label;
	logic [7:0]  probability;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	modport source (output valid, voxel_index, label_index, first_label, probability,
		red, green, blue, input ready);
	modport sink (input valid, voxel_index, label_index, first_label, probability,
		red, green, blue, output ready);
endinterface

interface plcba_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_voxel;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  out_alpha;
	logic [7:0]  best_label;
	logic [7:0]  best_probability;

	modport source (output valid, out_voxel, out_red, out_green, out_blue, out_alpha,
		best_label, best_probability, input ready);
	modport sink (input valid, out_voxel, out_red, out_green, out_blue, out_alpha,
		best_label, best_probability, output ready);
endinterface

/* rtl/core/prob_label_color_blend_argmax_top.sv */
// probability label compositor: voxel store read-modify-write
// result path: sample and store read registered, then multiply, then update into the result
// flow: one sample at a time, set by the single read-modify-write of the voxel
// store; a waiting result holds the update step until it is taken
// reset: control state and result valid clear at once; store contents stay
// undefined until a first-label sample writes them, no clearing pass
module prob_label_color_blend_argmax_top import plcba_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	plcba_in_if.sink   sample,
	plcba_out_if.source result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;

	entry_t mem_q [VOXEL_COUNT];
	entry_t rd_q;

	logic [VOX_W-1:0]            vox_q;
	logic [CH_W-1:0]             label_q;
	logic                        first_q;
	logic [CH_W-1:0]             prob_q;
	logic [NUM_CH-1:0][CH_W-1:0] color_q;

	prod_t  prod_s2;
	entry_t upd;

	logic             out_valid_q;
	logic [VOX_W-1:0] out_voxel_q;
	entry_t           out_entry_q;

	logic accept;
	logic commit;

	assign sample.ready = (state_q == ST_IDLE);
	assign accept = sample.valid && sample.ready;
	assign commit = (state_q == ST_UPD) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_UPD;
				ST_UPD:  if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// voxel store, read on transfer and written back on commit
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem_q[sample.voxel_index[VOX_AW-1:0]];
		end
		if (commit) begin
			mem_q[vox_q[VOX_AW-1:0]] <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vox_q      <= sample.voxel_index;
			label_q    <= sample.label_index;
			first_q    <= sample.first_label;
			prob_q     <= sample.probability;
			color_q[0] <= sample.red;
			color_q[1] <= sample.green;
			color_q[2] <= sample.blue;
			color_q[3] <= ALPHA;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			for (int m = 0; m < NUM_CH; m++) begin
				prod_s2[m] <= PROD_W'(color_q[m]) * PROD_W'(prob_q);
			end
		end
	end

	plcba_blend u_blend (
		.prod      (prod_s2),
		.old_entry (rd_q),
		.first     (first_q),
		.prob      (prob_q),
		.label     (label_q),
		.new_entry (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_voxel_q <= vox_q;
			out_entry_q <= upd;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.out_voxel        = out_voxel_q;
	assign result.out_red          = out_entry_q.color[0];
	assign result.out_green        = out_entry_q.color[1];
	assign result.out_blue         = out_entry_q.color[2];
	assign result.out_alpha        = out_entry_q.color[3];
	assign result.best_label       = out_entry_q.best_label;
	assign result.best_probability = out_entry_q.best_prob;

endmodule

/* rtl/core/plcba_blend.sv */
// per-channel scale, accumulate, saturate and best-label update
module plcba_blend import plcba_pkg::*; (
	input  prod_t           prod,
	input  entry_t          old_entry,
	input  logic            first,
	input  logic [CH_W-1:0] prob,
	input  logic [CH_W-1:0] label,
	output entry_t          new_entry
);

	logic [NUM_CH-1:0][CH_W-1:0] share;
	logic [NUM_CH-1:0][CH_W:0]   sum;

	always_comb begin
		for (int m = 0; m < NUM_CH; m++) begin
			// floor(x/255) for x up to 255*255, the largest product
			share[m] = CH_W'((PROD_W+1)'({1'b0, prod[m]} + (PROD_W+1)'(prod[m] >> CH_W)
				+ (PROD_W+1)'(1)) >> CH_W);
			sum[m] = {1'b0, share[m]} + (first ? '0 : {1'b0, old_entry.color[m]});
			new_entry.color[m] = sum[m][CH_W] ? CH_MAX : sum[m][CH_W-1:0];
		end
		if (first) begin
			new_entry.best_label = '0;
			new_entry.best_prob  = prob;
		end else if (prob > old_entry.best_prob) begin
			new_entry.best_label = label;
			new_entry.best_prob  = prob;
		end else begin
			new_entry.best_label = old_entry.best_label;
			new_entry.best_prob  = old_entry.best_prob;
		end
	end

endmodule

/* rtl/core/plcba_checker.sv */
// port-level checks of the compositor, bound to the top level
`include "prob_label_color_blend_argmax_top_defines.svh"

module plcba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_voxel,
	input logic [7:0]  best_probability
);

	// one sample in flight: no transfer right after another
	`PLCBA_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready)
	// a new result only while a sample was being worked on
	`PLCBA_ASSERT(a_result_from_work, $rose(out_valid) |-> !$past(in_ready))
	// a stalled result stays valid
	`PLCBA_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid)
	// a stalled result keeps its payload
	`PLCBA_ASSERT(a_out_stable,
		(out_valid && !out_ready) |=> ($stable(out_voxel) && $stable(best_probability)))

endmodule

bind prob_label_color_blend_argmax_top plcba_checker u_plcba_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sample.valid),
	.in_ready         (sample.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.out_voxel        (result.out_voxel),
	.best_probability (result.best_probability)
);
